### hdl/dsa_sv_pkg.sv
// Package with the shared constants and modular helpers of the signature checker.
package dsa_sv_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W = $clog2(WORD_W);

	localparam logic [WORD_W-1:0] HASH_KEY = WORD_W'(1234);

	// Reset values of the configuration registers.
	localparam logic [WORD_W-1:0] RST_PRIME = WORD_W'(13);
	localparam logic [WORD_W-1:0] RST_ORDER = WORD_W'(3);
	localparam logic [WORD_W-1:0] RST_GEN = WORD_W'(3);
	localparam logic [WORD_W-1:0] RST_KEY = WORD_W'(3);

	// Configuration register indexes.
	localparam logic [1:0] REG_PRIME = 2'd0;
	localparam logic [1:0] REG_ORDER = 2'd1;
	localparam logic [1:0] REG_GEN = 2'd2;
	localparam logic [1:0] REG_KEY = 2'd3;

	// (a + b) mod m for a, b below m.
	function automatic logic [WORD_W-1:0] add_mod(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] m);
		logic [WORD_W:0] sum;
		logic [WORD_W:0] red;
		sum = {1'b0, a} + {1'b0, b};
		red = sum - {1'b0, m};
		add_mod = (sum >= {1'b0, m}) ? red[WORD_W-1:0] : sum[WORD_W-1:0];
	endfunction

	// (a - b) mod m for a, b below m.
	function automatic logic [WORD_W-1:0] sub_mod(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] m);
		sub_mod = (a >= b) ? (a - b) : (a + (m - b));
	endfunction

endpackage

### hdl/dsa_signature_verify.sv
// Top level of the signature checker: configuration, sequencer and bit-serial modular unit.

// Each transfer on the input carries a message and a signature pair (r, s); the block
// answers with one result: verified, the computed v and a status bit that flags r or s
// equal to zero or not below q. The domain values p, q, g and the public key y must be
// written through the configuration port while the block is idle; the block itself does
// not enforce this. Divisions and modular products run on one bit-serial unit that does
// either a restoring division or a modular multiplication, one bit per cycle. An item
// takes one division and one product per extended Euclid step, then for each of the two
// exponentiations a reduction of the base, a squaring per exponent bit and a product
// when the bit is set, and small domains need fewer steps. A final product and a
// reduction mod q give v. A range error is answered without using the unit. Input is
// stalled until the result is in the output register.
module dsa_signature_verify (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [1:0]                   cfg_index,
	input  logic [dsa_sv_pkg::WORD_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [dsa_sv_pkg::WORD_W-1:0] message,
	input  logic [dsa_sv_pkg::WORD_W-1:0] sig_r,
	input  logic [dsa_sv_pkg::WORD_W-1:0] sig_s,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         verified,
	output logic [dsa_sv_pkg::WORD_W-1:0] computed_v,
	output logic                         status
);

	localparam int W = dsa_sv_pkg::WORD_W;
	localparam int CW = dsa_sv_pkg::CNT_W;

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_EU_TEST  = 5'd1;
	localparam logic [4:0] ST_EU_DIVGO = 5'd2;
	localparam logic [4:0] ST_EU_DIVW  = 5'd3;
	localparam logic [4:0] ST_EU_MULGO = 5'd4;
	localparam logic [4:0] ST_EU_MULW  = 5'd5;
	localparam logic [4:0] ST_U1_GO    = 5'd6;
	localparam logic [4:0] ST_U1_W     = 5'd7;
	localparam logic [4:0] ST_U2_GO    = 5'd8;
	localparam logic [4:0] ST_U2_W     = 5'd9;
	localparam logic [4:0] ST_PW_REDGO = 5'd10;
	localparam logic [4:0] ST_PW_REDW  = 5'd11;
	localparam logic [4:0] ST_PW_TEST  = 5'd12;
	localparam logic [4:0] ST_PW_MULGO = 5'd13;
	localparam logic [4:0] ST_PW_MULW  = 5'd14;
	localparam logic [4:0] ST_PW_SQGO  = 5'd15;
	localparam logic [4:0] ST_PW_SQW   = 5'd16;
	localparam logic [4:0] ST_V_GO     = 5'd17;
	localparam logic [4:0] ST_V_W      = 5'd18;
	localparam logic [4:0] ST_VR_GO    = 5'd19;
	localparam logic [4:0] ST_VR_W     = 5'd20;
	localparam logic [4:0] ST_OUT      = 5'd21;

	// Configuration registers.
	logic [W-1:0] prime_q, order_q, gen_q, key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= dsa_sv_pkg::RST_PRIME;
			order_q <= dsa_sv_pkg::RST_ORDER;
			gen_q <= dsa_sv_pkg::RST_GEN;
			key_q <= dsa_sv_pkg::RST_KEY;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dsa_sv_pkg::REG_PRIME: prime_q <= cfg_data;
				dsa_sv_pkg::REG_ORDER: order_q <= cfg_data;
				dsa_sv_pkg::REG_GEN:   gen_q <= cfg_data;
				dsa_sv_pkg::REG_KEY:   key_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A modulus p of zero behaves like one.
	logic [W-1:0] pm;
	assign pm = (prime_q == '0) ? W'(1) : prime_q;

	logic [4:0] state_q;
	logic in_xfer, range_err;
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer = in_valid && !in_stall;
	assign range_err = (sig_r == '0) || (sig_s == '0) || (sig_r >= order_q) ||
		(sig_s >= order_q);

	// Shared bit-serial unit: restoring division or double-and-add modular product.
	logic u_busy_q, u_div_q;
	logic [CW-1:0] u_cnt_q;
	logic [W-1:0] u_a_q, u_b_q, u_m_q, u_acc_q;
	logic l_go, l_div;
	logic [W-1:0] l_a, l_b, l_m;

	logic [W:0] rem_ext, rem_sub;
	logic rem_ge;
	logic [W-1:0] dbl, mac;
	assign rem_ext = {u_acc_q, u_b_q[W-1]};
	assign rem_ge = rem_ext >= {1'b0, u_a_q};
	assign rem_sub = rem_ext - {1'b0, u_a_q};
	assign dbl = dsa_sv_pkg::add_mod(u_acc_q, u_acc_q, u_m_q);
	assign mac = u_b_q[W-1] ? dsa_sv_pkg::add_mod(dbl, u_a_q, u_m_q) : dbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_busy_q <= 1'b0;
			u_div_q <= 1'b0;
			u_cnt_q <= '0;
		end else if (l_go) begin
			u_busy_q <= 1'b1;
			u_div_q <= l_div;
			u_cnt_q <= CW'(W - 1);
		end else if (u_busy_q) begin
			u_cnt_q <= u_cnt_q - CW'(1);
			if (u_cnt_q == '0) begin
				u_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (l_go) begin
			u_a_q <= l_a;
			u_b_q <= l_b;
			u_m_q <= l_m;
			u_acc_q <= '0;
		end else if (u_busy_q) begin
			if (u_div_q) begin
				u_acc_q <= rem_ge ? rem_sub[W-1:0] : rem_ext[W-1:0];
				u_b_q <= {u_b_q[W-2:0], rem_ge};
			end else begin
				u_acc_q <= mac;
				u_b_q <= {u_b_q[W-2:0], 1'b0};
			end
		end
	end

	// Working registers of the sequencer.
	logic [W-1:0] old_r_q, r_q, old_t_q, t_q, quot_q;
	logic [W-1:0] hash_q, sr_q, u1_q, u2_q, base_q, res_q, exp_q, pow1_q, v_q;
	logic pw_q, err_q;

	// Operand selection for each issue state.
	always_comb begin
		l_go = 1'b0;
		l_div = 1'b0;
		l_a = u_acc_q;
		l_b = res_q;
		l_m = pm;
		unique case (state_q)
			ST_EU_DIVGO: begin
				l_go = 1'b1; l_div = 1'b1; l_a = r_q; l_b = old_r_q;
			end
			ST_EU_MULGO: begin
				l_go = 1'b1; l_a = t_q; l_b = quot_q; l_m = order_q;
			end
			ST_U1_GO: begin
				l_go = 1'b1; l_a = old_t_q; l_b = hash_q; l_m = order_q;
			end
			ST_U2_GO: begin
				l_go = 1'b1; l_a = old_t_q; l_b = sr_q; l_m = order_q;
			end
			ST_PW_REDGO: begin
				l_go = 1'b1; l_div = 1'b1; l_a = pm; l_b = pw_q ? key_q : gen_q;
			end
			ST_PW_MULGO: begin
				l_go = 1'b1; l_a = base_q; l_b = res_q;
			end
			ST_PW_SQGO: begin
				l_go = 1'b1; l_a = base_q; l_b = base_q;
			end
			ST_V_GO: begin
				l_go = 1'b1; l_a = pow1_q; l_b = res_q;
			end
			ST_VR_GO: begin
				l_go = 1'b1; l_div = 1'b1; l_a = order_q; l_b = u_acc_q;
			end
			default: ;
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:     if (in_xfer) state_q <= range_err ? ST_OUT : ST_EU_TEST;
				ST_EU_TEST:  state_q <= (r_q == '0) ? ST_U1_GO : ST_EU_DIVGO;
				ST_EU_DIVGO: state_q <= ST_EU_DIVW;
				ST_EU_DIVW:  if (!u_busy_q) state_q <= ST_EU_MULGO;
				ST_EU_MULGO: state_q <= ST_EU_MULW;
				ST_EU_MULW:  if (!u_busy_q) state_q <= ST_EU_TEST;
				ST_U1_GO:    state_q <= ST_U1_W;
				ST_U1_W:     if (!u_busy_q) state_q <= ST_U2_GO;
				ST_U2_GO:    state_q <= ST_U2_W;
				ST_U2_W:     if (!u_busy_q) state_q <= ST_PW_REDGO;
				ST_PW_REDGO: state_q <= ST_PW_REDW;
				ST_PW_REDW:  if (!u_busy_q) state_q <= ST_PW_TEST;
				ST_PW_TEST: begin
					if (exp_q == '0) begin
						state_q <= pw_q ? ST_V_GO : ST_PW_REDGO;
					end else begin
						state_q <= exp_q[0] ? ST_PW_MULGO : ST_PW_SQGO;
					end
				end
				ST_PW_MULGO: state_q <= ST_PW_MULW;
				ST_PW_MULW:  if (!u_busy_q) state_q <= ST_PW_SQGO;
				ST_PW_SQGO:  state_q <= ST_PW_SQW;
				ST_PW_SQW:   if (!u_busy_q) state_q <= ST_PW_TEST;
				ST_V_GO:     state_q <= ST_V_W;
				ST_V_W:      if (!u_busy_q) state_q <= ST_VR_GO;
				ST_VR_GO:    state_q <= ST_VR_W;
				ST_VR_W:     if (!u_busy_q) state_q <= ST_OUT;
				ST_OUT:      if (!out_valid || !out_stall) state_q <= ST_IDLE;
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	// Sequencer data path.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					err_q <= range_err;
					old_r_q <= order_q;
					r_q <= sig_s;
					old_t_q <= '0;
					t_q <= W'(1);
					hash_q <= message ^ dsa_sv_pkg::HASH_KEY;
					sr_q <= sig_r;
					pw_q <= 1'b0;
				end
			end
			ST_EU_DIVW: begin
				// Quotient and remainder are taken before the unit is reused.
				if (!u_busy_q) begin
					quot_q <= u_b_q;
					old_r_q <= r_q;
					r_q <= u_acc_q;
				end
			end
			ST_EU_MULW: begin
				if (!u_busy_q) begin
					old_t_q <= t_q;
					t_q <= dsa_sv_pkg::sub_mod(old_t_q, u_acc_q, order_q);
				end
			end
			ST_EU_DIVGO: begin
				// The remainder of old_r / r lands in the unit accumulator.
			end
			ST_U1_W: if (!u_busy_q) u1_q <= u_acc_q;
			ST_U2_W: if (!u_busy_q) u2_q <= u_acc_q;
			ST_PW_REDW: begin
				if (!u_busy_q) begin
					base_q <= u_acc_q;
					res_q <= (pm == W'(1)) ? '0 : W'(1);
					exp_q <= pw_q ? u2_q : u1_q;
				end
			end
			ST_PW_TEST: begin
				if (exp_q == '0 && !pw_q) begin
					pow1_q <= res_q;
					pw_q <= 1'b1;
				end
			end
			ST_PW_MULW: if (!u_busy_q) res_q <= u_acc_q;
			ST_PW_SQW: begin
				if (!u_busy_q) begin
					base_q <= u_acc_q;
					exp_q <= {1'b0, exp_q[W-1:1]};
				end
			end
			ST_VR_W: if (!u_busy_q) v_q <= u_acc_q;
			default: ;
		endcase
	end

	// Output register; a new result loads when the old one is gone or leaves now.
	logic load_out;
	assign load_out = (state_q == ST_OUT) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status <= err_q;
			computed_v <= err_q ? '0 : v_q;
			verified <= !err_q && (v_q == sr_q);
		end
	end

	// Checks on the sequencer, the unit and the result.
	a_idle_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !u_busy_q)
		else $error("arithmetic unit busy while idle");

	a_mul_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(u_busy_q && !u_div_q && $past(l_go)) |-> (u_acc_q == '0))
		else $error("product accumulator not cleared at launch");

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (!verified && computed_v == '0))
		else $error("range error result carries a value");

	a_verified_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verified) |-> (computed_v != '0 && !status))
		else $error("verified result with zero v");

	a_out_after_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_OUT))
		else $error("result appeared outside the output step");

endmodule
